/* hw/rtl/tsum_pkg.sv */
// Shared constants, types and helpers for the three-term error-free binary64 sum.
`timescale 1ns / 1ps

package tsum_pkg;

  localparam int F64_W   = 64;
  // Register stages inside one binary64 adder.
  localparam int ADD_LAT = 5;

  typedef logic [F64_W-1:0] f64_t;

  localparam f64_t CANON_NAN = 64'h7FF8_0000_0000_0000;

  // Flip the sign bit so that an adder computes a difference.
  function automatic f64_t f64_neg(input f64_t v);
    f64_neg = {~v[63], v[62:0]};
  endfunction

endpackage

/* hw/rtl/three_sum_exact_fp64.sv */
// Top level: three chained error-free two-sum steps over binary64, fully pipelined.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | first, second, third addend (64 b each)
//   out_    | output    | out_valid/out_stall | high, middle, low part (64 b each)
//
// One word enters per cycle while no output stall holds the pipeline; the depth is set by the chain of eleven
// dependent five-stage adders (two-sum of x and y, two-sum with z, two-sum of the errors).
// Reset clears only the valid bits; the data path registers are not reset.
// A stalled output word freezes the whole pipeline, so in_stall follows it in the same cycle.
`timescale 1ns / 1ps

module three_sum_exact_fp64
  import tsum_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_first_addend,
  input  logic [63:0] in_second_addend,
  input  logic [63:0] in_third_addend,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_high_part,
  output logic [63:0] out_middle_part,
  output logic [63:0] out_low_part
);

  localparam int L     = ADD_LAT;
  localparam int DEPTH = 11 * L;

  logic             en;
  logic [DEPTH-1:0] vld_r;

  f64_t x, y, z;
  f64_t s1, bv1, av1, da1, db1, lo1;
  f64_t s2, bv2, av2, da2, db2, err2;
  f64_t s3, bv3, av3, da3, db3, lo3;

  f64_t x_d_r    [3*L];
  f64_t y_d_r    [3*L];
  f64_t z_d_r    [4*L];
  f64_t s1_d_r   [3*L];
  f64_t bv1_d_r  [L];
  f64_t s2_d_r   [9*L];
  f64_t bv2_d_r  [L];
  f64_t lo1_d_r  [4*L];
  f64_t err2_d_r [3*L];
  f64_t s3_d_r   [4*L];
  f64_t bv3_d_r  [L];

  assign x = in_first_addend;
  assign y = in_second_addend;
  assign z = in_third_addend;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // First two-sum: x and y.
  tsum_add u_a1  (.clk, .en, .a(x), .b(y), .s(s1));
  tsum_add u_a2  (.clk, .en, .a(s1), .b(f64_neg(x_d_r[L-1])), .s(bv1));
  tsum_add u_a3  (.clk, .en, .a(s1_d_r[L-1]), .b(f64_neg(bv1)), .s(av1));
  tsum_add u_a4  (.clk, .en, .a(x_d_r[3*L-1]), .b(f64_neg(av1)), .s(da1));
  tsum_add u_a5  (.clk, .en, .a(y_d_r[3*L-1]), .b(f64_neg(bv1_d_r[L-1])), .s(db1));
  tsum_add u_a6  (.clk, .en, .a(da1), .b(db1), .s(lo1));

  // Second two-sum: the leading part with z.
  tsum_add u_a7  (.clk, .en, .a(s1), .b(z_d_r[L-1]), .s(s2));
  tsum_add u_a8  (.clk, .en, .a(s2), .b(f64_neg(s1_d_r[L-1])), .s(bv2));
  tsum_add u_a9  (.clk, .en, .a(s2_d_r[L-1]), .b(f64_neg(bv2)), .s(av2));
  tsum_add u_a10 (.clk, .en, .a(s1_d_r[3*L-1]), .b(f64_neg(av2)), .s(da2));
  tsum_add u_a11 (.clk, .en, .a(z_d_r[4*L-1]), .b(f64_neg(bv2_d_r[L-1])), .s(db2));
  tsum_add u_a12 (.clk, .en, .a(da2), .b(db2), .s(err2));

  // Third two-sum: the two error terms.
  tsum_add u_a13 (.clk, .en, .a(lo1_d_r[L-1]), .b(err2), .s(s3));
  tsum_add u_a14 (.clk, .en, .a(s3), .b(f64_neg(lo1_d_r[2*L-1])), .s(bv3));
  tsum_add u_a15 (.clk, .en, .a(s3_d_r[L-1]), .b(f64_neg(bv3)), .s(av3));
  tsum_add u_a16 (.clk, .en, .a(lo1_d_r[4*L-1]), .b(f64_neg(av3)), .s(da3));
  tsum_add u_a17 (.clk, .en, .a(err2_d_r[3*L-1]), .b(f64_neg(bv3_d_r[L-1])), .s(db3));
  tsum_add u_a18 (.clk, .en, .a(da3), .b(db3), .s(lo3));

  // Delay lines that keep each operand in step with the adder that consumes it.
  always_ff @(posedge clk) begin
    if (en) begin
      x_d_r[0]    <= x;
      y_d_r[0]    <= y;
      z_d_r[0]    <= z;
      s1_d_r[0]   <= s1;
      bv1_d_r[0]  <= bv1;
      s2_d_r[0]   <= s2;
      bv2_d_r[0]  <= bv2;
      lo1_d_r[0]  <= lo1;
      err2_d_r[0] <= err2;
      s3_d_r[0]   <= s3;
      bv3_d_r[0]  <= bv3;
      for (int i = 1; i < 3*L; i++) begin
        x_d_r[i]    <= x_d_r[i-1];
        y_d_r[i]    <= y_d_r[i-1];
        s1_d_r[i]   <= s1_d_r[i-1];
        err2_d_r[i] <= err2_d_r[i-1];
      end
      for (int i = 1; i < 4*L; i++) begin
        z_d_r[i]   <= z_d_r[i-1];
        lo1_d_r[i] <= lo1_d_r[i-1];
        s3_d_r[i]  <= s3_d_r[i-1];
      end
      for (int i = 1; i < 9*L; i++) begin
        s2_d_r[i] <= s2_d_r[i-1];
      end
      for (int i = 1; i < L; i++) begin
        bv1_d_r[i] <= bv1_d_r[i-1];
        bv2_d_r[i] <= bv2_d_r[i-1];
        bv3_d_r[i] <= bv3_d_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  assign out_valid       = vld_r[DEPTH-1];
  assign out_high_part   = s2_d_r[9*L-1];
  assign out_middle_part = s3_d_r[4*L-1];
  assign out_low_part    = lo3;

  a_stall_freezes : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(vld_r))
    else $error("pipeline valid bits moved during an output stall");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word valid straight after reset");

  a_nan_canon : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_high_part[62:52] == 11'h7FF) && (out_high_part[51:0] != 52'd0))
    |-> (out_high_part == CANON_NAN))
    else $error("non-canonical NaN on the high part");

  a_low_canon : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_low_part[62:52] == 11'h7FF) && (out_low_part[51:0] != 52'd0))
    |-> (out_low_part == CANON_NAN))
    else $error("non-canonical NaN on the low part");

endmodule

/* hw/rtl/tsum_add.sv */
// Five-stage binary64 adder, round to nearest even, subnormals kept, NaN made canonical.
`timescale 1ns / 1ps

module tsum_add
  import tsum_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  f64_t a,
  input  f64_t b,
  output f64_t s
);

  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        inf_sign;
  } spec_t;

  typedef struct packed {
    spec_t       sp;
    logic        sign;
    logic        sub;
    logic [10:0] ex;
    logic [55:0] mb;
    logic [55:0] ms;
  } st1_t;

  typedef struct packed {
    spec_t       sp;
    logic        sign;
    logic        zsign;
    logic [10:0] ex;
    logic [56:0] sum;
  } st2_t;

  typedef struct packed {
    spec_t       sp;
    logic        sign;
    logic        zsign;
    logic        zero;
    logic [10:0] ex;
    logic [56:0] sum;
    logic [5:0]  lz;
  } st3_t;

  typedef struct packed {
    spec_t       sp;
    logic        sign;
    logic        zsign;
    logic        zero;
    logic [11:0] e_adj;
    logic [55:0] n;
  } st4_t;

  st1_t st1_r, st1_nxt;
  st2_t st2_r, st2_nxt;
  st3_t st3_r, st3_nxt;
  st4_t st4_r, st4_nxt;
  f64_t s_r, s_nxt;

  // Stage 1: unpack, order by magnitude, align the smaller operand.
  always_comb begin
    logic        a_nan, b_nan, a_inf, b_inf, swap;
    f64_t        big, sml;
    logic [10:0] eb, es, d;
    logic [5:0]  dsh;
    logic [55:0] mb, ms, ms_sh;
    logic        lost;
    a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
    b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    a_inf = (a[62:52] == 11'h7FF) && (a[51:0] == 52'd0);
    b_inf = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
    swap  = b[62:0] > a[62:0];
    big   = swap ? b : a;
    sml   = swap ? a : b;
    eb    = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
    es    = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
    d     = eb - es;
    dsh   = (d > 11'd56) ? 6'd56 : d[5:0];
    mb    = {big[62:52] != 11'd0, big[51:0], 3'b000};
    ms    = {sml[62:52] != 11'd0, sml[51:0], 3'b000};
    ms_sh = ms >> dsh;
    lost  = (ms & ((56'd1 << dsh) - 56'd1)) != 56'd0;
    st1_nxt.sp.nan      = a_nan || b_nan || (a_inf && b_inf && (a[63] ^ b[63]));
    st1_nxt.sp.inf      = a_inf || b_inf;
    st1_nxt.sp.inf_sign = a_inf ? a[63] : b[63];
    st1_nxt.sign        = big[63];
    st1_nxt.sub         = big[63] ^ sml[63];
    st1_nxt.ex          = eb;
    st1_nxt.mb          = mb;
    st1_nxt.ms          = {ms_sh[55:1], ms_sh[0] | lost};
  end

  // Stage 2: magnitude add or subtract; the larger operand keeps the result non-negative.
  always_comb begin
    st2_nxt.sp    = st1_r.sp;
    st2_nxt.sign  = st1_r.sign;
    st2_nxt.zsign = st1_r.sub ? 1'b0 : st1_r.sign;
    st2_nxt.ex    = st1_r.ex;
    st2_nxt.sum   = st1_r.sub ? ({1'b0, st1_r.mb} - {1'b0, st1_r.ms})
                              : ({1'b0, st1_r.mb} + {1'b0, st1_r.ms});
  end

  // Stage 3: leading-zero count of the raw sum.
  always_comb begin
    logic [5:0] lz;
    lz = 6'd57;
    for (int i = 0; i < 57; i++) begin
      if (st2_r.sum[i]) lz = 6'(56 - i);
    end
    st3_nxt.sp    = st2_r.sp;
    st3_nxt.sign  = st2_r.sign;
    st3_nxt.zsign = st2_r.zsign;
    st3_nxt.zero  = st2_r.sum == 57'd0;
    st3_nxt.ex    = st2_r.ex;
    st3_nxt.sum   = st2_r.sum;
    st3_nxt.lz    = lz;
  end

  // Stage 4: normalise; the left shift stops at the smallest exponent for subnormals.
  always_comb begin
    logic [5:0]  lead, sh;
    logic [10:0] room;
    logic [11:0] e12;
    logic [55:0] n;
    lead = st3_r.lz - 6'd1;
    room = st3_r.ex - 11'd1;
    sh   = ({5'd0, lead} < room) ? lead : room[5:0];
    if (st3_r.sum[56]) begin
      n   = {st3_r.sum[56:2], st3_r.sum[1] | st3_r.sum[0]};
      e12 = {1'b0, st3_r.ex} + 12'd1;
    end else begin
      n   = st3_r.sum[55:0] << sh;
      e12 = {1'b0, st3_r.ex} - {6'd0, sh};
    end
    st4_nxt.sp    = st3_r.sp;
    st4_nxt.sign  = st3_r.sign;
    st4_nxt.zsign = st3_r.zsign;
    st4_nxt.zero  = st3_r.zero;
    st4_nxt.e_adj = n[55] ? e12 : 12'd0;
    st4_nxt.n     = n;
  end

  // Stage 5: round; a carry out of the fraction moves into the exponent field on its own.
  always_comb begin
    logic        rnd, ovf;
    logic [62:0] packed_v;
    rnd      = st4_r.n[2] && (st4_r.n[1] || st4_r.n[0] || st4_r.n[3]);
    packed_v = {st4_r.e_adj[10:0], st4_r.n[54:3]} + {62'd0, rnd};
    ovf      = st4_r.e_adj[11] || (st4_r.e_adj[10:0] == 11'h7FF) ||
               (packed_v[62:52] == 11'h7FF);
    if (st4_r.sp.nan) begin
      s_nxt = CANON_NAN;
    end else if (st4_r.sp.inf) begin
      s_nxt = {st4_r.sp.inf_sign, 11'h7FF, 52'd0};
    end else if (st4_r.zero) begin
      s_nxt = {st4_r.zsign, 63'd0};
    end else if (ovf) begin
      s_nxt = {st4_r.sign, 11'h7FF, 52'd0};
    end else begin
      s_nxt = {st4_r.sign, packed_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1_r <= st1_nxt;
      st2_r <= st2_nxt;
      st3_r <= st3_nxt;
      st4_r <= st4_nxt;
      s_r   <= s_nxt;
    end
  end

  assign s = s_r;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the three-term error-free binary64 sum block.
`timescale 1ns / 1ps

module testbench;
  import tsum_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_first_addend = '0;
  logic [63:0] in_second_addend = '0;
  logic [63:0] in_third_addend = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_high_part;
  logic [63:0] out_middle_part;
  logic [63:0] out_low_part;

  typedef struct packed {
    f64_t high_part;
    f64_t middle_part;
    f64_t low_part;
  } sum_parts_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 4 * 11 * ADD_LAT;

  sum_parts_t parts_pending[$];
  int         mismatch_count = 0;
  int         words_sent = 0;
  int         words_checked = 0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         hold_cycles = 0;
  int         quiet_cycles = 0;

  three_sum_exact_fp64 dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // NaNs leave the block in one canonical encoding.
  function automatic f64_t canon_bits(input real v);
    f64_t b;
    b = $realtobits(v);
    if (b[62:52] == 11'h7FF && b[51:0] != 0) b = CANON_NAN;
    return b;
  endfunction

  function automatic void two_sum(input real a, input real b, output real s, output real e);
    real bv;
    real av;
    s  = a + b;
    bv = s - a;
    av = s - bv;
    e  = (a - av) + (b - bv);
  endfunction

  function automatic sum_parts_t split_three_sum(input f64_t x, input f64_t y, input f64_t z);
    real hi1;
    real lo1;
    real hi;
    real err2;
    real mid;
    real lo;
    sum_parts_t p;
    two_sum($bitstoreal(x), $bitstoreal(y), hi1, lo1);
    two_sum(hi1, $bitstoreal(z), hi, err2);
    two_sum(lo1, err2, mid, lo);
    p.high_part   = canon_bits(hi);
    p.middle_part = canon_bits(mid);
    p.low_part    = canon_bits(lo);
    return p;
  endfunction

  function automatic f64_t rand_special();
    case ($urandom_range(7))
      0: return 64'h0000_0000_0000_0000;
      1: return 64'h8000_0000_0000_0000;
      2: return 64'h7FF0_0000_0000_0000;
      3: return 64'hFFF0_0000_0000_0000;
      4: return {$urandom_range(1) == 1, 11'h7FF, 20'h0, $urandom_range(1, 32'hFFFF_FFFF)};
      5: return {$urandom_range(1) == 1, 63'h7FEF_FFFF_FFFF_FFFF};
      6: return {$urandom_range(1) == 1, 11'h000, 20'($urandom), 32'($urandom)};
      default: return {$urandom_range(1) == 1, 11'h001, 52'h0};
    endcase
  endfunction

  // Mostly values of similar magnitude, so that the error terms carry real content.
  function automatic f64_t rand_addend();
    int pick;
    pick = $urandom_range(9);
    if (pick < 2) return {$urandom, $urandom};
    if (pick < 3) return rand_special();
    return {$urandom_range(1) == 1, 11'($urandom_range(1023 + 60, 1023 - 60)),
            20'($urandom), 32'($urandom)};
  endfunction

  task automatic report_mismatch(input string field, input f64_t got, input f64_t want);
    $display("mismatch on %s: got %h, expected %h", field, got, want);
    mismatch_count++;
  endtask

  task automatic send_word(input f64_t x, input f64_t y, input f64_t z);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid         = 1'b1;
    in_first_addend  = x;
    in_second_addend = y;
    in_third_addend  = z;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      parts_pending.push_back(split_three_sum(in_first_addend, in_second_addend,
                                              in_third_addend));
  end

  always @(posedge clk) begin
    sum_parts_t want;
    if (rst_n && out_valid && !out_stall) begin
      words_checked++;
      if (parts_pending.size() == 0) begin
        $display("result word with nothing expected: %h %h %h",
                 out_high_part, out_middle_part, out_low_part);
        mismatch_count++;
      end else begin
        want = parts_pending.pop_front();
        if (out_high_part !== want.high_part)
          report_mismatch("high_part", out_high_part, want.high_part);
        if (out_middle_part !== want.middle_part)
          report_mismatch("middle_part", out_middle_part, want.middle_part);
        if (out_low_part !== want.low_part)
          report_mismatch("low_part", out_low_part, want.low_part);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic wait_drained();
    go_idle();
    while (parts_pending.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    f64_t edge_vals[12];
    edge_vals = '{64'h0, 64'h8000_0000_0000_0000, 64'h3FF0_0000_0000_0000,
                  64'hBFF0_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
                  64'hFFEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
                  64'h800F_FFFF_FFFF_FFFF, 64'h7FF0_0000_0000_0000,
                  64'hFFF0_0000_0000_0000, 64'h7FF4_0000_0000_0001,
                  64'hFFFF_FFFF_FFFF_FFFF};
    foreach (edge_vals[i]) send_word(edge_vals[i], edge_vals[(i + 5) % 12], edge_vals[i]);
    // Opposite-signed zeros, exact cancellation and rounding ties.
    send_word(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h0);
    send_word(64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_word(64'h4340_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'h3CA0_0000_0000_0000);
    send_word(64'h3FF0_0000_0000_0001, 64'h3CA0_0000_0000_0000, 64'hBCA0_0000_0000_0000);
    send_word(64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF);
    send_word(64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
    send_word(64'h0010_0000_0000_0000, 64'h800F_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001);
    send_word(64'h4000_0000_0000_0000, 64'h3950_0000_0000_0000, 64'h3260_0000_0000_0000);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0);
    wait_drained();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_p, input int count);
    f64_t x;
    f64_t y;
    send_idle_pct = idle_pct;
    stall_pct     = stall_p;
    repeat (count) begin
      x = rand_addend();
      y = rand_addend();
      // A share of words nearly cancel so the errors dominate.
      if ($urandom_range(3) == 0) send_word(x, f64_neg(x) ^ 64'($urandom_range(7)), y);
      else send_word(x, y, rand_addend());
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    @(negedge clk);
    hold_cycles = 400;
    repeat (120) send_word(rand_addend(), rand_addend(), rand_addend());
    wait_drained();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_phase(0, 0, 150);
    test_random_phase(81, 0, 120);
    test_random_phase(0, 81, 120);
    test_random_phase(10, 10, 150);
    test_backpressure();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (parts_pending.size() != 0) begin
      $display("%0d expected words never arrived", parts_pending.size());
      mismatch_count++;
    end
    $display("Sent %0d words and checked %0d results across idle, stall and hold-off phases.",
             words_sent, words_checked);
    $display("Operands covered signed zeros, subnormals, infinities, NaNs and cancellation.");
    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
